[design/periodic_task_dispatcher_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task dispatcher
// Each macro expands to one concurrent assertion clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/ptd_pkg.sv]
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and constants of the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

	// Operation codes; OP_NONE also marks a registration that is out of range.
	typedef enum logic [1:0] {
		OP_TICK     = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_REGISTER = 2'd2,
		OP_NONE     = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [1:0]  grp;
		logic [3:0]  tsk;
		logic [15:0] period;
		logic [15:0] first;
	} cmd_t;

	localparam logic [1:0] QUEUE_DEPTH = 2'd2;

endpackage

[design/ptd_ram.sv]
// ----------------------------------------------------------------------------
// ptd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/ptd_front.sv]
// ----------------------------------------------------------------------------
// ptd_front
// Accepts command beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`include "periodic_task_dispatcher_top_assert.svh"

module ptd_front #(
	parameter int GROUP_COUNT     = 4,
	parameter int TASKS_PER_GROUP = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         operation,
	input  logic [1:0]         group_sel,
	input  logic [3:0]         task_sel,
	input  logic [15:0]        period_ticks,
	input  logic [15:0]        first_tick,
	output logic               q_valid,
	output ptd_pkg::cmd_t      q_cmd,
	input  logic               pop
);

	ptd_pkg::cmd_t q_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	logic          push;
	ptd_pkg::cmd_t cls;

	// A registration aimed outside the table is turned into a no-op here.
	always_comb begin
		cls.op     = ptd_pkg::op_t'(operation);
		cls.grp    = group_sel;
		cls.tsk    = task_sel;
		cls.period = period_ticks;
		cls.first  = first_tick;
		if (operation == ptd_pkg::OP_REGISTER &&
			!((32'(group_sel) < GROUP_COUNT) && (32'(task_sel) < TASKS_PER_GROUP))) begin
			cls.op = ptd_pkg::OP_NONE;
		end
	end

	assign cmd_stall = (cnt_q == ptd_pkg::QUEUE_DEPTH);
	assign push      = cmd_valid && !cmd_stall;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_cmd     = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_q] <= cls;
		end
	end

	`PTD_ASSERT_SAME(a_pop_nonempty, pop, cnt_q != 2'd0, "pop from an empty queue")
	`PTD_ASSERT_NEXT(a_fill_bound, 1'b1, cnt_q <= ptd_pkg::QUEUE_DEPTH, "queue overfilled")
	`PTD_ASSERT_NEXT(a_push_counted, push && !pop, cnt_q != 2'd0, "pushed beat was not counted")

endmodule

[design/ptd_back.sv]
// ----------------------------------------------------------------------------
// ptd_back
// Executes queued commands: enrollment, the tick walk over the task table
// and the priority dispatch. Drives the result register.
// ----------------------------------------------------------------------------
`include "periodic_task_dispatcher_top_assert.svh"

module ptd_back #(
	parameter int GROUP_COUNT       = 4,
	parameter int BACKGROUND_GROUPS = 1,
	parameter int TASKS_PER_GROUP   = 16,
	parameter int START_WINDOW      = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  ptd_pkg::cmd_t q_cmd,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output logic          dispatched,
	output logic [1:0]    run_group,
	output logic [3:0]    run_task
);

	localparam int FG     = (GROUP_COUNT > BACKGROUND_GROUPS) ?
	                        (GROUP_COUNT - BACKGROUND_GROUPS) : 0;
	localparam int GW     = $clog2(GROUP_COUNT);
	localparam int TW     = $clog2(TASKS_PER_GROUP);
	localparam int SLOTS  = GROUP_COUNT * TASKS_PER_GROUP;
	localparam int SW     = $clog2(SLOTS);
	localparam int LAST_G = (FG > 0) ? (FG - 1) : 0;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_TICK   = 6'b000010,
		S_FIND   = 6'b000100,
		S_PICK   = 6'b001000,
		S_CHK    = 6'b010000,
		S_RESULT = 6'b100000
	} state_t;

	state_t st_q;
	logic [15:0] tick_q;
	logic [GW-1:0] pg_q;
	logic [TW-1:0] pt_q;
	logic [GW-1:0] fg_q;
	logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] enr_q;
	logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] act_q;
	logic [GROUP_COUNT-1:0][TASKS_PER_GROUP-1:0] pend_q;
	logic       res_disp_q;
	logic [1:0] res_grp_q;
	logic [3:0] res_tsk_q;
	logic       rsp_valid_q;
	logic       disp_q;
	logic [1:0] rgrp_q;
	logic [3:0] rtsk_q;

	logic [GW-1:0] nx_g;
	logic [TW-1:0] nx_t;
	logic          walk_last;
	logic [GW-1:0] gsel;
	logic          gany;
	logic [TW-1:0] lb_idx;
	logic          ram_we;
	logic [SW-1:0] ram_waddr;
	logic [31:0]   ram_wdata;
	logic [SW-1:0] ram_raddr;
	logic [31:0]   ram_rdata;
	logic [15:0]   rd_period;
	logic [15:0]   rd_start;
	logic [15:0]   elapsed;
	logic [GW-1:0] reg_g;
	logic [TW-1:0] reg_t;
	logic          reg_fg;
	logic          tick_due;
	logic          out_free;

	assign rd_period = ram_rdata[31:16];
	assign rd_start  = ram_rdata[15:0];
	assign elapsed   = tick_q - rd_start;
	assign reg_g     = GW'(q_cmd.grp);
	assign reg_t     = TW'(q_cmd.tsk);
	assign reg_fg    = (32'(reg_g) < FG);
	assign pop       = (st_q == S_IDLE) && q_valid;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Walk order over the foreground part of the table: task bit fastest.
	always_comb begin
		nx_g = pg_q;
		nx_t = pt_q + TW'(1);
		if (pt_q == TW'(TASKS_PER_GROUP - 1)) begin
			nx_t = '0;
			nx_g = pg_q + GW'(1);
		end
	end
	assign walk_last = (pg_q == GW'(LAST_G)) && (pt_q == TW'(TASKS_PER_GROUP - 1));

	// A periodic task that is not waiting on its start window is due once a
	// full period has elapsed.
	assign tick_due = enr_q[pg_q][pt_q] && !pend_q[pg_q][pt_q] && (elapsed >= rd_period);

	always_comb begin
		gsel = '0;
		gany = 1'b0;
		for (int g = GROUP_COUNT - 1; g >= 0; g--) begin
			if (|act_q[g]) begin
				gsel = GW'(g);
				gany = 1'b1;
			end
		end
	end

	always_comb begin
		lb_idx = '0;
		for (int t = TASKS_PER_GROUP - 1; t >= 0; t--) begin
			if (act_q[fg_q][t]) begin
				lb_idx = TW'(t);
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = SW'(SW'(pg_q) * SW'(TASKS_PER_GROUP) + SW'(pt_q));
		ram_wdata = {rd_period, rd_start + rd_period};
		if (pop && q_cmd.op == ptd_pkg::OP_REGISTER) begin
			ram_we    = 1'b1;
			ram_waddr = SW'(SW'(reg_g) * SW'(TASKS_PER_GROUP) + SW'(reg_t));
			ram_wdata = {q_cmd.period, q_cmd.first};
		end else if (st_q == S_TICK && tick_due) begin
			ram_we = 1'b1;
		end
	end

	always_comb begin
		unique case (st_q)
			S_IDLE:  ram_raddr = '0;
			S_PICK:  ram_raddr = SW'(SW'(fg_q) * SW'(TASKS_PER_GROUP) + SW'(lb_idx));
			default: ram_raddr = SW'(SW'(nx_g) * SW'(TASKS_PER_GROUP) + SW'(nx_t));
		endcase
	end

	ptd_ram #(
		.WIDTH(32),
		.DEPTH(SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			tick_q      <= '0;
			pg_q        <= '0;
			pt_q        <= '0;
			fg_q        <= '0;
			enr_q       <= '0;
			act_q       <= '0;
			pend_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.op)
							ptd_pkg::OP_TICK: begin
								tick_q <= tick_q + 16'd1;
								pg_q   <= '0;
								pt_q   <= '0;
								st_q   <= (FG > 0) ? S_TICK : S_RESULT;
							end
							ptd_pkg::OP_DISPATCH: begin
								st_q <= S_FIND;
							end
							ptd_pkg::OP_REGISTER: begin
								enr_q[reg_g][reg_t] <= 1'b1;
								if (reg_fg) begin
									pend_q[reg_g][reg_t] <= 1'b1;
								end
								st_q <= S_RESULT;
							end
							ptd_pkg::OP_NONE: begin
								st_q <= S_RESULT;
							end
						endcase
					end
				end
				S_TICK: begin
					if (enr_q[pg_q][pt_q] && pend_q[pg_q][pt_q]) begin
						if (elapsed <= 16'(START_WINDOW)) begin
							pend_q[pg_q][pt_q] <= 1'b0;
							act_q[pg_q][pt_q]  <= 1'b1;
						end
					end else if (tick_due) begin
						act_q[pg_q][pt_q] <= 1'b1;
					end
					if (walk_last) begin
						st_q <= S_RESULT;
					end else begin
						pg_q <= nx_g;
						pt_q <= nx_t;
					end
				end
				S_FIND: begin
					if (gany) begin
						fg_q <= gsel;
						st_q <= S_PICK;
					end else begin
						// Nothing runnable: reload the background groups.
						for (int g = FG; g < GROUP_COUNT; g++) begin
							act_q[g] <= enr_q[g];
						end
						st_q <= S_RESULT;
					end
				end
				S_PICK: begin
					pt_q <= lb_idx;
					st_q <= S_CHK;
				end
				S_CHK: begin
					act_q[fg_q][pt_q] <= 1'b0;
					if ((32'(fg_q) < FG) && rd_period == 16'd0) begin
						enr_q[fg_q][pt_q] <= 1'b0;
					end
					st_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase

			if (st_q == S_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_disp_q <= 1'b0;
			res_grp_q  <= 2'd0;
			res_tsk_q  <= 4'd0;
		end else if (st_q == S_CHK) begin
			res_disp_q <= 1'b1;
			res_grp_q  <= 2'(fg_q);
			res_tsk_q  <= 4'(pt_q);
		end
		if (st_q == S_RESULT && out_free) begin
			disp_q <= res_disp_q;
			rgrp_q <= res_grp_q;
			rtsk_q <= res_tsk_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign dispatched = disp_q;
	assign run_group  = rgrp_q;
	assign run_task   = rtsk_q;

	`PTD_ASSERT_SAME(a_chk_active, st_q == S_CHK, act_q[fg_q][pt_q], "picked task is not active")
	`PTD_ASSERT_SAME(a_walk_fg, st_q == S_TICK, 32'(pg_q) < FG, "tick walk left the foreground")
	`PTD_ASSERT_NEXT(a_find_next, st_q == S_FIND, st_q == S_PICK || st_q == S_RESULT,
		"dispatch search went astray")

endmodule

[design/periodic_task_dispatcher_top.sv]
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_top
// Priority task scheduler: enrolls tasks, activates due tasks on each tick
// and hands out the highest priority active task on each dispatch request.
// ----------------------------------------------------------------------------
// Every command beat gives exactly one result beat, in order. Commands enter a
// two-beat queue, so the command side can take beats while a result waits to
// be taken, until the queue is full. In the execution unit a registration or
// an unknown command goes from idle to the result state, a dispatch request
// passes the find, pick and check states (find goes straight to the result
// state when no task is active), and a tick walks the foreground task table
// one entry per cycle through the single read port of the start/period RAM.
// While a result is stalled, the execution unit waits in its result state.

module periodic_task_dispatcher_top #(
	parameter int GROUP_COUNT       = 4,
	parameter int BACKGROUND_GROUPS = 1,
	parameter int TASKS_PER_GROUP   = 16,
	parameter int START_WINDOW      = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  operation,
	input  logic [1:0]  group_sel,
	input  logic [3:0]  task_sel,
	input  logic [15:0] period_ticks,
	input  logic [15:0] first_tick,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        dispatched,
	output logic [1:0]  run_group,
	output logic [3:0]  run_task
);

	logic          q_valid;
	ptd_pkg::cmd_t q_cmd;
	logic          pop;

	ptd_front #(
		.GROUP_COUNT     (GROUP_COUNT),
		.TASKS_PER_GROUP (TASKS_PER_GROUP)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.operation    (operation),
		.group_sel    (group_sel),
		.task_sel     (task_sel),
		.period_ticks (period_ticks),
		.first_tick   (first_tick),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.pop          (pop)
	);

	ptd_back #(
		.GROUP_COUNT       (GROUP_COUNT),
		.BACKGROUND_GROUPS (BACKGROUND_GROUPS),
		.TASKS_PER_GROUP   (TASKS_PER_GROUP),
		.START_WINDOW      (START_WINDOW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.dispatched (dispatched),
		.run_group  (run_group),
		.run_task   (run_task)
	);

endmodule
